[sv/smpf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Screen mode pixel fetch - shared definitions
// Geometry, register indexes, mode masks, configuration bundle and the
// screen coordinate transform.
// ----------------------------------------------------------------------------
package smpf_pkg;

    // Geometry: 128x128 pixels, two pixels per byte
    localparam int SCREEN_SIDE = 128;
    localparam int COORD_W     = $clog2(SCREEN_SIDE);
    localparam int STORE_DEPTH = SCREEN_SIDE * SCREEN_SIDE / 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PIX_W       = 4;
    localparam int COLOR_W     = 8;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_MODE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAST_CTRL    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCR_PAL_LOW  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCR_PAL_HIGH = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RST_PAL_LOW  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RST_PAL_HIGH = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_FLG_LOW  = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_FLG_HIGH = 8'd7;

    // Reset values of the screen palette (identity map)
    localparam logic [63:0] SCR_PAL_LOW_RST  = 64'h0706050403020100;
    localparam logic [63:0] SCR_PAL_HIGH_RST = 64'h0F0E0D0C0B0A0908;

    // Screen mode decode
    localparam logic [7:0] ROT_MASK     = 8'hbc;
    localparam logic [7:0] ROT_CODE     = 8'h84;
    localparam logic [7:0] X_MASK       = 8'hbd;
    localparam logic [7:0] X_MIRROR     = 8'h05;
    localparam logic [7:0] X_STRETCH    = 8'h01;
    localparam logic [7:0] X_FLIP       = 8'h81;
    localparam logic [7:0] Y_MASK       = 8'hbe;
    localparam logic [7:0] Y_MIRROR     = 8'h06;
    localparam logic [7:0] Y_STRETCH    = 8'h02;
    localparam logic [7:0] Y_FLIP       = 8'h82;

    // Raster mode decode
    localparam logic [7:0] RASTER_ALT   = 8'h10;
    localparam logic [7:0] RASTER_GRAD  = 8'h30;
    localparam logic [7:0] RASTER_COLOR = 8'h0f;

    // Item operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Configuration seen by the color stage
    typedef struct packed {
        logic [7:0]   rast_ctrl;
        logic [127:0] scr_pal;
        logic [127:0] raster_palette;
        logic [127:0] row_flags;
    } smpf_cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } smpf_coord_t;

    // Axis mapping helpers
    function automatic logic [COORD_W-1:0] axis_map(
        input logic [COORD_W-1:0] v,
        input logic [7:0]         sel,
        input logic [7:0]         mirror_code,
        input logic [7:0]         stretch_code,
        input logic [7:0]         flip_code
    );
        logic [COORD_W-1:0] r;
        r = v;
        if (sel == mirror_code)
        begin
            r = v[COORD_W-1] ? ~v : v;          // min(v, max - v)
        end
        else if (sel == stretch_code)
        begin
            r = v >> 1;
        end
        else if (sel == flip_code)
        begin
            r = ~v;
        end
        return r;
    endfunction

    // Screen mode coordinate transform
    function automatic smpf_coord_t coord_map(
        input logic [7:0]         mode,
        input logic [COORD_W-1:0] x_in,
        input logic [COORD_W-1:0] y_in
    );
        smpf_coord_t c;
        c.x = x_in;
        c.y = y_in;
        if ((mode & ROT_MASK) == ROT_CODE)
        begin
            if (mode[0])
            begin
                c.x = y_in;
                c.y = x_in;
            end
            if (mode[1])
            begin
                c.x = ~c.x;
            end
            // bit 1 of (mode + 1)
            if (mode[1] ^ mode[0])
            begin
                c.y = ~c.y;
            end
        end
        else
        begin
            c.x = axis_map(x_in, mode & X_MASK, X_MIRROR, X_STRETCH, X_FLIP);
            c.y = axis_map(y_in, mode & Y_MASK, Y_MIRROR, Y_STRETCH, Y_FLIP);
        end
        return c;
    endfunction

endpackage

[sv/screen_mode_pixel_fetch_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Screen mode pixel fetch core
// 128x128 4-bit framebuffer with screen mode coordinate mapping and raster
// palette effects; read items return one palette index each.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Content
// s_axis    in   s_tvalid/s_tready  write byte or pixel request
// m_axis    out  m_tvalid/m_tready  palette index of requested pixel
// cfg       in   cfg_valid/ready    register index and 64-bit data
//
// One item per cycle. Write items go to the framebuffer RAM in the accept
// cycle; read items address the RAM in the accept cycle, color the byte in
// the next; the output register takes the result when that stage advances.
// The single RAM port sets the rate. Reset clears handshake state and loads
// register defaults; framebuffer contents are not cleared. A stalled output
// holds the RAM stage, and s_tready drops only while both are full.
// ----------------------------------------------------------------------------
module screen_mode_pixel_fetch_core (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pos_x[6:0], pos_y[13:7], byte_address[26:14],
                                   // byte_data[34:27], zero[39:35]
    input  logic [0:0]  s_tuser,   // operation[0]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // color_index[7:0]
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int CW = smpf_pkg::COORD_W;
    localparam int AW = smpf_pkg::ADDR_W;

    // Configuration registers
    logic [7:0]  screen_mode_reg;
    logic [7:0]  rast_ctrl_reg;
    logic [63:0] scr_pal_low_reg, scr_pal_high_reg;
    logic [63:0] rst_pal_low_reg, rst_pal_high_reg;
    logic [63:0] row_flg_low_reg, row_flg_high_reg;

    // Pipeline
    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_odd_reg;
    logic [CW-1:0]        s1_row_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_color_reg;

    logic                 s_acc;
    logic                 s1_adv;
    logic                 op;
    logic [CW-1:0]        in_x, in_y;
    logic [AW-1:0]        in_addr;
    logic [7:0]           in_byte;
    smpf_pkg::smpf_coord_t mc;
    logic [AW-1:0]        ram_addr;
    logic [7:0]           ram_rdata;
    logic                 ram_we;
    smpf_pkg::smpf_cfg_t  cfg;
    logic [7:0]           color;

    // Input field unpack
    assign op      = s_tuser[0];
    assign in_x    = s_tdata[6:0];
    assign in_y    = s_tdata[13:7];
    assign in_addr = s_tdata[26:14];
    assign in_byte = s_tdata[34:27];

    // Handshake
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_color_reg;

    // Coordinate mapping and RAM address
    always_comb
    begin
        mc       = smpf_pkg::coord_map(screen_mode_reg, in_x, in_y);
        ram_we   = (op == smpf_pkg::OP_WRITE);
        ram_addr = ram_we ? in_addr : {mc.y, mc.x[CW-1:1]};
    end

    smpf_ram #(
        .WIDTH (8),
        .DEPTH (smpf_pkg::STORE_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .en    (s_acc),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_byte),
        .rdata (ram_rdata)
    );

    // Color stage
    always_comb
    begin
        cfg.rast_ctrl      = rast_ctrl_reg;
        cfg.scr_pal        = {scr_pal_high_reg, scr_pal_low_reg};
        cfg.raster_palette = {rst_pal_high_reg, rst_pal_low_reg};
        cfg.row_flags      = {row_flg_high_reg, row_flg_low_reg};
    end

    smpf_color u_color (
        .cfg     (cfg),
        .byte_in (ram_rdata),
        .odd_x   (s1_odd_reg),
        .row     (s1_row_reg),
        .color   (color)
    );

    // Stage valid next values
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (s_acc)
        begin
            s1_valid_next = (op == smpf_pkg::OP_READ);
        end

        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_odd_reg <= mc.x[0];
            s1_row_reg <= mc.y;
        end
        if (s1_adv)
        begin
            out_color_reg <= color;
        end
    end

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_mode_reg  <= 8'd0;
            rast_ctrl_reg    <= 8'd0;
            scr_pal_low_reg  <= smpf_pkg::SCR_PAL_LOW_RST;
            scr_pal_high_reg <= smpf_pkg::SCR_PAL_HIGH_RST;
            rst_pal_low_reg  <= 64'd0;
            rst_pal_high_reg <= 64'd0;
            row_flg_low_reg  <= 64'd0;
            row_flg_high_reg <= 64'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                smpf_pkg::REG_SCREEN_MODE:  screen_mode_reg  <= cfg_data[7:0];
                smpf_pkg::REG_RAST_CTRL:    rast_ctrl_reg    <= cfg_data[7:0];
                smpf_pkg::REG_SCR_PAL_LOW:  scr_pal_low_reg  <= cfg_data;
                smpf_pkg::REG_SCR_PAL_HIGH: scr_pal_high_reg <= cfg_data;
                smpf_pkg::REG_RST_PAL_LOW:  rst_pal_low_reg  <= cfg_data;
                smpf_pkg::REG_RST_PAL_HIGH: rst_pal_high_reg <= cfg_data;
                smpf_pkg::REG_ROW_FLG_LOW:  row_flg_low_reg  <= cfg_data;
                smpf_pkg::REG_ROW_FLG_HIGH: row_flg_high_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Assertions
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (op == smpf_pkg::OP_WRITE) |=> !s1_valid_reg)
        else $error("write transaction started a result");

    a_read_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (op == smpf_pkg::OP_READ) |=> s1_valid_reg)
        else $error("read transaction lost in RAM stage");

    a_stall_holds_data: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(ram_rdata))
        else $error("RAM read data changed while stage stalled");

    a_stage_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("result not loaded into output register");

endmodule

[sv/smpf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, registered read data updated on read accesses only.
// ----------------------------------------------------------------------------
module smpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

[sv/smpf_color.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Screen mode pixel fetch - color stage
// Picks the nibble out of the fetched byte and applies the raster mode or
// the screen palette to produce the final palette index.
// ----------------------------------------------------------------------------
module smpf_color (
    input  smpf_pkg::smpf_cfg_t                cfg,
    input  logic [7:0]                         byte_in,
    input  logic                               odd_x,
    input  logic [smpf_pkg::COORD_W-1:0]       row,
    output logic [smpf_pkg::COLOR_W-1:0]       color
);

    logic [smpf_pkg::PIX_W-1:0] nib;
    logic                       flag;
    logic [smpf_pkg::PIX_W-1:0] grad_idx;
    logic                       alt_hit;
    logic                       grad_hit;

    // Nibble, row flag and gradient entry
    always_comb
    begin
        nib      = odd_x ? byte_in[7:4] : byte_in[3:0];
        flag     = cfg.row_flags[row];
        grad_idx = row[smpf_pkg::COORD_W-1:3] + {3'd0, flag};
        alt_hit  = (cfg.rast_ctrl == smpf_pkg::RASTER_ALT) && flag;
        grad_hit = ((cfg.rast_ctrl & smpf_pkg::RASTER_GRAD) == smpf_pkg::RASTER_GRAD)
                   && ((cfg.rast_ctrl & smpf_pkg::RASTER_COLOR) == {4'd0, nib});
    end

    // Palette select; raster colors bypass the screen palette
    always_comb
    begin
        if (alt_hit)
        begin
            color = cfg.raster_palette[nib*8 +: 8];
        end
        else if (grad_hit)
        begin
            color = cfg.raster_palette[grad_idx*8 +: 8];
        end
        else
        begin
            color = cfg.scr_pal[nib*8 +: 8];
        end
    end

endmodule
